// ----- sv/textured_wall_column_raster_unit_macros.svh -----
// assertion macros shared by the wall column raster modules
`ifndef TEXTURED_WALL_COLUMN_RASTER_UNIT_MACROS_SVH
`define TEXTURED_WALL_COLUMN_RASTER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define TWCR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TWCR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/twcr_pkg.sv -----
// shared types and constants of the wall column raster unit
package twcr_pkg;

    localparam int DIST_W    = 24;
    localparam int DIR_W     = 18;
    localparam int COL_W     = 10;
    localparam int POS_W     = 26;
    localparam int LH_W      = 12;
    localparam int PIX_W     = 19;
    localparam int TEX_SEL_W = 2;
    localparam int TEXEL_W   = 6;
    localparam int CFG_IDX_W = 1;

    localparam int DIV_NUM_W = 27;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [LH_W-1:0] MAX_LINE = 12'd4095;

    localparam logic OP_SETUP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 1'b1;

    localparam logic [TEX_SEL_W-1:0] TEX_NORTH = 2'd0;
    localparam logic [TEX_SEL_W-1:0] TEX_SOUTH = 2'd1;
    localparam logic [TEX_SEL_W-1:0] TEX_EAST  = 2'd2;
    localparam logic [TEX_SEL_W-1:0] TEX_WEST  = 2'd3;

    typedef struct packed {
        logic load_setup;
        logic tick;
        logic div_start;
        logic div_sel_step;
        logic load_lh;
        logic load_step;
        logic load_pos;
    } twcr_cmd_t;

    typedef struct packed {
        logic span_active;
        logic div_done;
    } twcr_status_t;

endpackage

// ----- sv/textured_wall_column_raster_unit.sv -----
// top level of the textured wall column raster unit
// row tick: accepted every cycle while the result register drains, result registered for the next cycle
// column setup: the next item waits while the sequencer runs two passes of the
// restoring divider (line height, then texture row step)
// a tick outside an active span and a setup item give no result
// synchronous active-low reset clears the sequencer, span and player position
module textured_wall_column_raster_unit #(
    parameter int SCREEN_HEIGHT = 480,
    parameter int SCREEN_WIDTH  = 640,
    parameter int TEXTURE_SIZE  = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [twcr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [twcr_pkg::DIST_W-1:0]           cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_op,
    input  logic [twcr_pkg::COL_W-1:0]            s_column,
    input  logic                                  s_wall_side,
    input  logic signed [twcr_pkg::DIR_W-1:0]     s_dir_x,
    input  logic signed [twcr_pkg::DIR_W-1:0]     s_dir_y,
    input  logic                                  s_step_x_positive,
    input  logic                                  s_step_y_negative,
    input  logic [twcr_pkg::DIST_W-1:0]           s_wall_distance,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [twcr_pkg::PIX_W-1:0]            m_pixel_index,
    output logic [twcr_pkg::TEX_SEL_W-1:0]        m_texture_select,
    output logic [twcr_pkg::TEXEL_W-1:0]          m_texel_x,
    output logic [twcr_pkg::TEXEL_W-1:0]          m_texel_y,
    output logic                                  m_last_row
);

    twcr_pkg::twcr_cmd_t    cmd;
    twcr_pkg::twcr_status_t status;

    assign cfg_ready = 1'b1;

    twcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    twcr_dp #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .TEXTURE_SIZE  (TEXTURE_SIZE)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_column          (s_column),
        .s_wall_side       (s_wall_side),
        .s_dir_x           (s_dir_x),
        .s_dir_y           (s_dir_y),
        .s_step_x_positive (s_step_x_positive),
        .s_step_y_negative (s_step_y_negative),
        .s_wall_distance   (s_wall_distance),
        .cmd               (cmd),
        .status            (status),
        .m_pixel_index     (m_pixel_index),
        .m_texture_select  (m_texture_select),
        .m_texel_x         (m_texel_x),
        .m_texel_y         (m_texel_y),
        .m_last_row        (m_last_row)
    );

endmodule

// ----- sv/twcr_div.sv -----
// restoring divider, one quotient bit per cycle
`include "textured_wall_column_raster_unit_macros.svh"

module twcr_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [twcr_pkg::DIV_NUM_W-1:0]     numerator,
    input  logic [twcr_pkg::DIV_DEN_W-1:0]     divisor,
    output logic                               done,
    output logic [twcr_pkg::DIV_NUM_W-1:0]     quotient
);

    localparam int NW = twcr_pkg::DIV_NUM_W;
    localparam int DW = twcr_pkg::DIV_DEN_W;
    localparam int CW = twcr_pkg::DIV_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;

    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;

    always_comb begin
        rem_sh     = {rem_reg, quo_reg[NW-1]};
        diff       = {1'b0, rem_sh} - {2'b00, dvs_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = CW'(NW - 1);
            rem_next   = '0;
            quo_next   = numerator;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            if (!diff[DW+1]) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `TWCR_ASSERT_NOW(a_done_not_busy, aclk, aresetn, done_reg, !busy_reg, "divider done while busy")

endmodule

// ----- sv/twcr_ctrl.sv -----
// controller state machine: handshakes and setup sequencing
`include "textured_wall_column_raster_unit_macros.svh"

module twcr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  twcr_pkg::twcr_status_t status,
    output twcr_pkg::twcr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LH_START,
        ST_LH_WAIT,
        ST_STEP_START,
        ST_STEP_WAIT,
        ST_POS
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        s_ready    = (state_reg == ST_IDLE) && out_free;
        accept     = s_valid && s_ready;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_op == twcr_pkg::OP_SETUP) begin
                    cmd.load_setup = 1'b1;
                    state_next     = ST_LH_START;
                end
                cmd.tick = accept && s_op == twcr_pkg::OP_TICK && status.span_active;
            end
            ST_LH_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_LH_WAIT;
            end
            ST_LH_WAIT: begin
                if (status.div_done) begin
                    cmd.load_lh = 1'b1;
                    state_next  = ST_STEP_START;
                end
            end
            ST_STEP_START: begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_step = 1'b1;
                state_next       = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (status.div_done) begin
                    cmd.load_step = 1'b1;
                    state_next    = ST_POS;
                end
            end
            ST_POS: begin
                cmd.load_pos = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.tick) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `TWCR_ASSERT_NOW(a_done_in_wait, aclk, aresetn, status.div_done, (state_reg == ST_LH_WAIT) || (state_reg == ST_STEP_WAIT), "division finished outside a wait state")
    `TWCR_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg, "pending item dropped")

endmodule

// ----- sv/twcr_dp.sv -----
// datapath: configuration, column setup arithmetic and row stepping
`include "textured_wall_column_raster_unit_macros.svh"

module twcr_dp #(
    parameter int SCREEN_HEIGHT = 480,
    parameter int SCREEN_WIDTH  = 640,
    parameter int TEXTURE_SIZE  = 64
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [twcr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [twcr_pkg::DIST_W-1:0]             cfg_data,
    input  logic [twcr_pkg::COL_W-1:0]              s_column,
    input  logic                                    s_wall_side,
    input  logic signed [twcr_pkg::DIR_W-1:0]       s_dir_x,
    input  logic signed [twcr_pkg::DIR_W-1:0]       s_dir_y,
    input  logic                                    s_step_x_positive,
    input  logic                                    s_step_y_negative,
    input  logic [twcr_pkg::DIST_W-1:0]             s_wall_distance,
    input  twcr_pkg::twcr_cmd_t                     cmd,
    output twcr_pkg::twcr_status_t                  status,
    output logic [twcr_pkg::PIX_W-1:0]              m_pixel_index,
    output logic [twcr_pkg::TEX_SEL_W-1:0]          m_texture_select,
    output logic [twcr_pkg::TEXEL_W-1:0]            m_texel_x,
    output logic [twcr_pkg::TEXEL_W-1:0]            m_texel_y,
    output logic                                    m_last_row
);

    localparam int ROW_W = $clog2(SCREEN_HEIGHT + 1);
    localparam int TX_W  = $clog2(TEXTURE_SIZE);
    localparam int HALF  = SCREEN_HEIGHT / 2;
    localparam int NW    = twcr_pkg::DIV_NUM_W;
    localparam int DW    = twcr_pkg::DIV_DEN_W;
    localparam int PW    = twcr_pkg::POS_W;
    localparam int LW    = twcr_pkg::LH_W;
    localparam int DIR_MSB = twcr_pkg::DIR_W - 1;
    localparam logic [NW-1:0] LH_NUM   = NW'(SCREEN_HEIGHT) << 16;
    localparam logic [NW-1:0] STEP_NUM = NW'(TEXTURE_SIZE) << 16;

    logic [twcr_pkg::DIST_W-1:0]    player_x_reg, player_y_reg;
    logic                           span_active_reg, span_active_next;

    logic [twcr_pkg::DIST_W-1:0]    dist_reg;
    logic [31:0]                    prod_reg;
    logic                           side_reg;
    logic                           mirror_reg;
    logic [twcr_pkg::COL_W-1:0]     column_reg;
    logic [twcr_pkg::TEX_SEL_W-1:0] texture_reg;
    logic [twcr_pkg::TEXEL_W-1:0]   texel_x_reg;
    logic [LW-1:0]                  lh_reg;
    logic [LW-2:0]                  offset_reg;
    logic [ROW_W-1:0]               current_row_reg;
    logic [ROW_W-1:0]               end_row_reg;
    logic [PW-1:0]                  row_step_reg;
    logic [PW-1:0]                  texpos_reg;

    logic [twcr_pkg::PIX_W-1:0]     pix_reg;
    logic [twcr_pkg::TEX_SEL_W-1:0] out_tex_reg;
    logic [twcr_pkg::TEXEL_W-1:0]   out_tx_reg;
    logic [twcr_pkg::TEXEL_W-1:0]   out_ty_reg;
    logic                           out_last_reg;

    logic                           div_done;
    logic [NW-1:0]                  quotient;
    logic [NW-1:0]                  div_num;
    logic [DW-1:0]                  div_den;

    logic signed [42:0]             prod_full;
    logic [twcr_pkg::TEX_SEL_W-1:0] texture_new;
    logic                           mirror_new;
    logic [31:0]                    hit_frac;
    logic [TX_W-1:0]                tx;
    logic [15:0]                    tx_wide;
    logic [LW-1:0]                  lh_sat;
    logic [LW-1:0]                  half_ext;
    logic [LW-1:0]                  half_scr;
    logic [LW-1:0]                  start_row;
    logic [LW-1:0]                  end_sum;
    logic [LW-1:0]                  end_row;
    logic [LW-1:0]                  offset;
    logic [36:0]                    pos_prod;
    logic [31:0]                    pix_full;
    logic [15:0]                    ty_wide;
    logic [ROW_W:0]                 row_inc;
    logic                           last;

    assign div_num = cmd.div_sel_step ? STEP_NUM : LH_NUM;
    assign div_den = cmd.div_sel_step ? DW'(lh_reg) : dist_reg;

    twcr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .numerator (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (quotient)
    );

    always_comb begin
        prod_full = $signed({1'b0, s_wall_distance}) * (s_wall_side ? s_dir_x : s_dir_y);
        if (s_wall_side && s_step_y_negative) begin
            texture_new = twcr_pkg::TEX_NORTH;
        end else if (s_wall_side) begin
            texture_new = twcr_pkg::TEX_SOUTH;
        end else if (s_step_x_positive) begin
            texture_new = twcr_pkg::TEX_EAST;
        end else begin
            texture_new = twcr_pkg::TEX_WEST;
        end
        mirror_new = s_wall_side ? s_dir_y[DIR_MSB] : (!s_dir_x[DIR_MSB] && |s_dir_x);

        hit_frac = (side_reg ? {player_x_reg[15:0], 16'h0000}
                             : {player_y_reg[15:0], 16'h0000}) + prod_reg;
        tx       = hit_frac[31 -: TX_W];
        if (mirror_reg) begin
            tx = ~tx;
        end
        tx_wide = 16'(tx);

        if (quotient > NW'(twcr_pkg::MAX_LINE)) begin
            lh_sat = twcr_pkg::MAX_LINE;
        end else if (quotient == '0) begin
            lh_sat = LW'(1);
        end else begin
            lh_sat = quotient[LW-1:0];
        end
        half_ext  = {1'b0, lh_sat[LW-1:1]};
        half_scr  = LW'(HALF);
        start_row = (half_ext > half_scr) ? '0 : half_scr - half_ext;
        offset    = (half_ext > half_scr) ? half_ext - half_scr : '0;
        end_sum   = half_scr + half_ext;
        end_row   = (end_sum >= LW'(SCREEN_HEIGHT)) ? LW'(SCREEN_HEIGHT) : end_sum;

        pos_prod = 37'(offset_reg) * 37'(row_step_reg);

        pix_full = 32'(current_row_reg) * 32'(SCREEN_WIDTH) + 32'(column_reg);
        ty_wide  = 16'(texpos_reg[16 +: TX_W]);
        row_inc  = {1'b0, current_row_reg} + 1'b1;
        last     = row_inc >= {1'b0, end_row_reg};

        span_active_next = span_active_reg;
        if (cmd.load_setup) begin
            span_active_next = 1'b0;
        end else if (cmd.load_pos) begin
            span_active_next = current_row_reg < end_row_reg;
        end else if (cmd.tick && last) begin
            span_active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            player_x_reg    <= '0;
            player_y_reg    <= '0;
            span_active_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    twcr_pkg::CFG_PLAYER_X: player_x_reg <= cfg_data;
                    twcr_pkg::CFG_PLAYER_Y: player_y_reg <= cfg_data;
                    default: ;
                endcase
            end
            span_active_reg <= span_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_setup) begin
            dist_reg    <= s_wall_distance;
            prod_reg    <= prod_full[31:0];
            side_reg    <= s_wall_side;
            mirror_reg  <= mirror_new;
            column_reg  <= s_column;
            texture_reg <= texture_new;
        end
        if (cmd.load_lh) begin
            texel_x_reg     <= tx_wide[twcr_pkg::TEXEL_W-1:0];
            lh_reg          <= lh_sat;
            offset_reg      <= offset[LW-2:0];
            current_row_reg <= start_row[ROW_W-1:0];
            end_row_reg     <= end_row[ROW_W-1:0];
        end
        if (cmd.load_step) begin
            row_step_reg <= quotient[PW-1:0];
        end
        if (cmd.load_pos) begin
            texpos_reg <= pos_prod[PW-1:0];
        end
        if (cmd.tick) begin
            pix_reg         <= pix_full[twcr_pkg::PIX_W-1:0];
            out_tex_reg     <= texture_reg;
            out_tx_reg      <= texel_x_reg;
            out_ty_reg      <= ty_wide[twcr_pkg::TEXEL_W-1:0];
            out_last_reg    <= last;
            texpos_reg      <= texpos_reg + row_step_reg;
            current_row_reg <= row_inc[ROW_W-1:0];
        end
    end

    assign status.span_active = span_active_reg;
    assign status.div_done    = div_done;

    assign m_pixel_index    = pix_reg;
    assign m_texture_select = out_tex_reg;
    assign m_texel_x        = out_tx_reg;
    assign m_texel_y        = out_ty_reg;
    assign m_last_row       = out_last_reg;

    `TWCR_ASSERT_NOW(a_span_in_range, aclk, aresetn, span_active_reg, current_row_reg < end_row_reg, "active span past its end row")

endmodule

// ----- test/wall_column_checker.sv -----
// checker that models the wall column raster unit and compares its pixel stream
`timescale 1ns / 1ps
module wall_column_checker #(
    parameter int SCREEN_HEIGHT = 480,
    parameter int SCREEN_WIDTH  = 640,
    parameter int TEXTURE_SIZE  = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [twcr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [twcr_pkg::DIST_W-1:0]           cfg_data,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_op,
    input  logic [twcr_pkg::COL_W-1:0]            s_column,
    input  logic                                  s_wall_side,
    input  logic signed [twcr_pkg::DIR_W-1:0]     s_dir_x,
    input  logic signed [twcr_pkg::DIR_W-1:0]     s_dir_y,
    input  logic                                  s_step_x_positive,
    input  logic                                  s_step_y_negative,
    input  logic [twcr_pkg::DIST_W-1:0]           s_wall_distance,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [twcr_pkg::PIX_W-1:0]            m_pixel_index,
    input  logic [twcr_pkg::TEX_SEL_W-1:0]        m_texture_select,
    input  logic [twcr_pkg::TEXEL_W-1:0]          m_texel_x,
    input  logic [twcr_pkg::TEXEL_W-1:0]          m_texel_y,
    input  logic                                  m_last_row,
    output int                                    mismatches,
    output int                                    pixels_due,
    output logic                                  column_open
);

    localparam int PIX_W     = twcr_pkg::PIX_W;
    localparam int TEX_SEL_W = twcr_pkg::TEX_SEL_W;
    localparam int TEXEL_W   = twcr_pkg::TEXEL_W;
    localparam int DIST_W    = twcr_pkg::DIST_W;
    localparam int POS_W     = twcr_pkg::POS_W;
    localparam int COL_W     = twcr_pkg::COL_W;
    localparam int DIR_W     = twcr_pkg::DIR_W;

    localparam longint HALF_HEIGHT = SCREEN_HEIGHT / 2;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_index;
        logic [TEX_SEL_W-1:0] texture;
        logic [TEXEL_W-1:0]   texel_x;
        logic [TEXEL_W-1:0]   texel_y;
        logic                 last_row;
    } wall_pixel_t;

    wall_pixel_t          pending_pixels[$];
    logic [DIST_W-1:0]    player_x = '0;
    logic [DIST_W-1:0]    player_y = '0;
    logic [POS_W-1:0]     tex_pos = '0;
    logic [POS_W-1:0]     row_step = '0;
    logic [8:0]           row = '0;
    logic [9:0]           end_row = '0;
    logic [TEXEL_W-1:0]   col_texel = '0;
    logic [TEX_SEL_W-1:0] col_texture = '0;
    logic [COL_W-1:0]     col_index = '0;
    logic                 span_on = 1'b0;
    int                   errors = 0;

    assign mismatches  = errors;
    assign column_open = span_on;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic open_column(input logic [COL_W-1:0] column, input logic side,
                               input logic signed [DIR_W-1:0] dx,
                               input logic signed [DIR_W-1:0] dy,
                               input logic sxp, input logic syn,
                               input logic [DIST_W-1:0] wall_dist);
        longint      hit;
        longint      texel;
        longint      height;
        longint      top_row;
        longint      bottom_row;
        longint      step_full;
        longint      pos_full;
        logic [31:0] frac;
        if (side && syn) col_texture = twcr_pkg::TEX_NORTH;
        else if (side) col_texture = twcr_pkg::TEX_SOUTH;
        else if (sxp) col_texture = twcr_pkg::TEX_EAST;
        else col_texture = twcr_pkg::TEX_WEST;

        if (side) hit = (longint'(player_x) <<< 16) + longint'(wall_dist) * longint'(dx);
        else hit = (longint'(player_y) <<< 16) + longint'(wall_dist) * longint'(dy);
        frac = hit[31:0];
        texel = (longint'(frac) * TEXTURE_SIZE) >>> 32;
        if ((!side && dx > 0) || (side && dy < 0)) texel = TEXTURE_SIZE - 1 - texel;
        col_texel = texel[TEXEL_W-1:0];

        if (wall_dist == 0) height = twcr_pkg::MAX_LINE;
        else height = (longint'(SCREEN_HEIGHT) <<< 16) / longint'(wall_dist);
        if (height > twcr_pkg::MAX_LINE) height = twcr_pkg::MAX_LINE;
        if (height < 1) height = 1;

        top_row = HALF_HEIGHT - height / 2;
        if (top_row < 0) top_row = 0;
        bottom_row = HALF_HEIGHT + height / 2;
        if (bottom_row >= SCREEN_HEIGHT) bottom_row = SCREEN_HEIGHT;

        step_full = (longint'(TEXTURE_SIZE) <<< 16) / height;
        row_step = step_full[POS_W-1:0];
        pos_full = (top_row - HALF_HEIGHT + height / 2) * longint'(row_step);
        tex_pos = pos_full[POS_W-1:0];
        row = top_row[8:0];
        end_row = bottom_row[9:0];
        col_index = column;
        span_on = top_row < bottom_row;
    endtask

    task automatic next_pixel(output wall_pixel_t px);
        longint flat;
        longint tex_row;
        px.last_row = (int'(row) + 1 >= int'(end_row));
        flat = longint'(row) * SCREEN_WIDTH + longint'(col_index);
        px.pixel_index = flat[PIX_W-1:0];
        px.texture = col_texture;
        px.texel_x = col_texel;
        tex_row = (longint'(tex_pos) >>> 16) & (TEXTURE_SIZE - 1);
        px.texel_y = tex_row[TEXEL_W-1:0];
        tex_pos = tex_pos + row_step;
        row = row + 9'd1;
        if (px.last_row) span_on = 1'b0;
    endtask

    always @(posedge aclk) begin : follow_stream
        wall_pixel_t want;
        if (!aresetn) begin
            player_x = '0;
            player_y = '0;
            tex_pos = '0;
            row_step = '0;
            row = '0;
            end_row = '0;
            col_texel = '0;
            col_texture = '0;
            col_index = '0;
            span_on = 1'b0;
            pending_pixels.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel %0d", m_pixel_index));
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_pixel_index !== want.pixel_index)
                        report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                                  m_pixel_index, want.pixel_index));
                    if (m_texture_select !== want.texture)
                        report_mismatch($sformatf("texture_select %0d, expected %0d",
                                                  m_texture_select, want.texture));
                    if (m_texel_x !== want.texel_x)
                        report_mismatch($sformatf("texel_x %0d, expected %0d",
                                                  m_texel_x, want.texel_x));
                    if (m_texel_y !== want.texel_y)
                        report_mismatch($sformatf("texel_y %0d, expected %0d",
                                                  m_texel_y, want.texel_y));
                    if (m_last_row !== want.last_row)
                        report_mismatch($sformatf("last_row %0b, expected %0b at pixel %0d",
                                                  m_last_row, want.last_row,
                                                  want.pixel_index));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == twcr_pkg::CFG_PLAYER_X) player_x = cfg_data;
                else player_y = cfg_data;
            end
            if (s_valid && s_ready) begin
                if (s_op == twcr_pkg::OP_SETUP) begin
                    open_column(s_column, s_wall_side, s_dir_x, s_dir_y,
                                s_step_x_positive, s_step_y_negative, s_wall_distance);
                end else if (span_on) begin
                    next_pixel(want);
                    pending_pixels.push_back(want);
                end
            end
        end
        pixels_due = pending_pixels.size();
    end

endmodule

// ----- test/tb_top.sv -----
// testbench top: drives column setups and row ticks into the wall column raster unit
`timescale 1ns / 1ps
module tb_top;

    localparam int DIST_W    = twcr_pkg::DIST_W;
    localparam int DIR_W     = twcr_pkg::DIR_W;
    localparam int CFG_IDX_W = twcr_pkg::CFG_IDX_W;
    localparam int COL_W     = twcr_pkg::COL_W;
    localparam int PIX_W     = twcr_pkg::PIX_W;
    localparam int TEX_SEL_W = twcr_pkg::TEX_SEL_W;
    localparam int TEXEL_W   = twcr_pkg::TEXEL_W;

    localparam int SETUP_CYCLES = 80;
    localparam int QUIET_LIMIT  = 4000;
    localparam int STALL_CYCLES = 400;
    localparam int PHASE_ITEMS  = 460;

    localparam logic [DIST_W-1:0] DIST_TWO_ROWS = 24'd15728640;
    localparam logic [DIST_W-1:0] DIST_ONE_LINE = 24'd15728641;
    localparam logic [DIST_W-1:0] DIST_SAT_EDGE = 24'd7681;
    localparam logic [DIST_W-1:0] DIST_FAR      = 24'hFFFFFF;
    localparam logic [DIR_W-1:0]  DIR_MIN       = 18'h20000;
    localparam logic [DIR_W-1:0]  DIR_MAX       = 18'h1FFFF;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [DIST_W-1:0]           cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_op = twcr_pkg::OP_SETUP;
    logic [COL_W-1:0]            s_column = '0;
    logic                        s_wall_side = 1'b0;
    logic signed [DIR_W-1:0]     s_dir_x = '0;
    logic signed [DIR_W-1:0]     s_dir_y = '0;
    logic                        s_step_x_positive = 1'b0;
    logic                        s_step_y_negative = 1'b0;
    logic [DIST_W-1:0]           s_wall_distance = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [PIX_W-1:0]            m_pixel_index;
    logic [TEX_SEL_W-1:0]        m_texture_select;
    logic [TEXEL_W-1:0]          m_texel_x;
    logic [TEXEL_W-1:0]          m_texel_y;
    logic                        m_last_row;

    int   mismatches;
    int   pixels_due;
    logic column_open;
    int   tx_idle_pct = 38;
    int   rx_idle_pct = 38;
    int   hold_requests = 0;
    int   quiet_cycles = 0;

    always #1 aclk = ~aclk;

    textured_wall_column_raster_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_column          (s_column),
        .s_wall_side       (s_wall_side),
        .s_dir_x           (s_dir_x),
        .s_dir_y           (s_dir_y),
        .s_step_x_positive (s_step_x_positive),
        .s_step_y_negative (s_step_y_negative),
        .s_wall_distance   (s_wall_distance),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pixel_index     (m_pixel_index),
        .m_texture_select  (m_texture_select),
        .m_texel_x         (m_texel_x),
        .m_texel_y         (m_texel_y),
        .m_last_row        (m_last_row)
    );

    wall_column_checker u_pixel_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_column          (s_column),
        .s_wall_side       (s_wall_side),
        .s_dir_x           (s_dir_x),
        .s_dir_y           (s_dir_y),
        .s_step_x_positive (s_step_x_positive),
        .s_step_y_negative (s_step_y_negative),
        .s_wall_distance   (s_wall_distance),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pixel_index     (m_pixel_index),
        .m_texture_select  (m_texture_select),
        .m_texel_x         (m_texel_x),
        .m_texel_y         (m_texel_y),
        .m_last_row        (m_last_row),
        .mismatches        (mismatches),
        .pixels_due        (pixels_due),
        .column_open       (column_open)
    );

    initial begin : pixel_sink
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [COL_W-1:0] column,
                             input logic side, input logic [DIR_W-1:0] dx,
                             input logic [DIR_W-1:0] dy, input logic sxp, input logic syn,
                             input logic [DIST_W-1:0] wall_dist);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_column <= column;
        s_wall_side <= side;
        s_dir_x <= dx;
        s_dir_y <= dy;
        s_step_x_positive <= sxp;
        s_step_y_negative <= syn;
        s_wall_distance <= wall_dist;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_setup(input logic [COL_W-1:0] column, input logic side,
                              input logic [DIR_W-1:0] dx, input logic [DIR_W-1:0] dy,
                              input logic sxp, input logic syn,
                              input logic [DIST_W-1:0] wall_dist);
        send_item(twcr_pkg::OP_SETUP, column, side, dx, dy, sxp, syn, wall_dist);
    endtask

    task automatic send_tick();
        send_item(twcr_pkg::OP_TICK, COL_W'($urandom), 1'($urandom), DIR_W'($urandom),
                  DIR_W'($urandom), 1'($urandom), 1'($urandom), DIST_W'($urandom));
    endtask

    function automatic logic [DIR_W-1:0] pick_direction();
        logic [DIR_W-1:0] dir;
        dir = DIR_W'($urandom);
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: dir = DIR_MIN;
                1: dir = DIR_MAX;
                2: dir = '0;
                default: dir = 18'd1;
            endcase
        end
        return dir;
    endfunction

    task automatic send_random_column();
        logic [COL_W-1:0]  column;
        logic [DIST_W-1:0] wall_dist;
        int                pick;
        column = COL_W'($urandom_range(639));
        if ($urandom_range(15) == 0) column = COL_W'($urandom_range(1023, 640));
        pick = $urandom_range(99);
        // mostly far walls so spans stay short, a few full-height ones
        if (pick < 60) wall_dist = DIST_W'($urandom_range(16777215, 1000000));
        else if (pick < 85) wall_dist = DIST_W'($urandom_range(999999, 65536));
        else if (pick < 93) wall_dist = DIST_W'($urandom_range(65535, 1));
        else if (pick < 95) wall_dist = '0;
        else wall_dist = DIST_W'($urandom);
        send_setup(column, 1'($urandom), pick_direction(), pick_direction(), 1'($urandom),
                   1'($urandom), wall_dist);
    endtask

    task automatic run_columns(input int quota);
        int sent;
        int cut;
        int ticks;
        sent = 0;
        while (sent < quota) begin
            send_random_column();
            sent++;
            cut = ($urandom_range(9) == 0) ? $urandom_range(6) : 1000;
            ticks = 0;
            while (column_open && ticks < cut) begin
                send_tick();
                ticks++;
                sent++;
            end
            if ($urandom_range(7) == 0) repeat ($urandom_range(3, 1)) send_tick();
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pixels_due != 0) @(negedge aclk);
        repeat (SETUP_CYCLES) @(negedge aclk);
    endtask

    task automatic place_player(input logic [DIST_W-1:0] x, input logic [DIST_W-1:0] y);
        cfg_valid <= 1'b1;
        cfg_index <= twcr_pkg::CFG_PLAYER_X;
        cfg_data <= x;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_index <= twcr_pkg::CFG_PLAYER_Y;
        cfg_data <= y;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        place_player(24'hFFFFFF, 24'h000000);

        // tick with no span open
        send_tick();
        // zero distance, north texture, full-height span
        send_setup(10'd0, 1'b1, DIR_MIN, DIR_MAX, 1'b0, 1'b1, 24'd0);
        repeat (3) send_tick();
        // two-row span, south mirrored, column beyond the screen
        send_setup(10'd1023, 1'b1, DIR_MAX, DIR_MIN, 1'b1, 1'b0, DIST_TWO_ROWS);
        repeat (3) send_tick();
        // farthest wall, east mirrored, empty span
        send_setup(10'd639, 1'b0, DIR_MAX, DIR_MIN, 1'b1, 1'b1, DIST_FAR);
        send_tick();
        send_setup(10'd320, 1'b0, DIR_MIN, DIR_MIN, 1'b0, 1'b0, DIST_TWO_ROWS);
        repeat (2) send_tick();
        // edge of height saturation, then abandoned by the next setup
        send_setup(10'd5, 1'b0, '0, DIR_MAX, 1'b1, 1'b0, DIST_SAT_EDGE);
        repeat (2) send_tick();
        send_setup(10'd638, 1'b1, DIR_MAX, '0, 1'b0, 1'b1, 24'd1);
        repeat (2) send_tick();
        // line height of one gives an empty span
        send_setup(10'd100, 1'b1, '0, 18'd1, 1'b1, 1'b0, DIST_ONE_LINE);
        send_tick();

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: place_player(24'h000000, 24'h000000);
                1: place_player(24'hFFFFFF, 24'hFFFFFF);
                default: place_player(DIST_W'($urandom), DIST_W'($urandom));
            endcase
            if (phase == 1) hold_requests++;
            if (phase == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 38;
                rx_idle_pct = 38;
            end
            run_columns(PHASE_ITEMS);
        end
        settle();

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/twcr_pkg.sv
sv/twcr_div.sv
sv/twcr_ctrl.sv
sv/twcr_dp.sv
sv/textured_wall_column_raster_unit.sv
test/wall_column_checker.sv
test/tb_top.sv
